### hw/rtl/hvn_pkg.sv
// Shared constants and types for the hashed value-noise height core.
`timescale 1ns / 1ps
`default_nettype none
package hvn_pkg;

	localparam logic [31:0] HASH_MUL_X = 32'h85ebca6b;
	localparam logic [31:0] HASH_MUL_Y = 32'hc2b2ae35;
	localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;
	localparam logic [8:0]  BYTE_BIAS  = 9'd128;

	localparam int unsigned STAGES = 9;

	localparam logic ADDR_SEED = 1'b0;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} hash_en_t;

endpackage
`default_nettype wire

### hw/rtl/hvn_corner.sv
// Corner hash pipeline: avalanche mix of one corner, returns centred low byte.
`timescale 1ns / 1ps
`default_nettype none
module hvn_corner (
	input  wire logic              clk,
	input  wire hvn_pkg::hash_en_t en,
	input  wire logic [31:0]       fold,
	input  wire logic [31:0]       px,
	input  wire logic [31:0]       py,
	output      logic signed [8:0] r_s5
);

	logic [31:0] h0;
	logic [31:0] h1;
	logic [31:0] m_s3;
	logic [31:0] g;
	logic [31:0] m_s4;
	logic [7:0]  lo_byte;

	assign h0      = fold ^ px ^ py;
	assign h1      = h0 ^ (h0 >> 16);
	assign g       = m_s3 ^ (m_s3 >> 15);
	assign lo_byte = m_s4[7:0] ^ m_s4[23:16];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			m_s3 <= h1 * hvn_pkg::MIX_MUL_A;
		end
		if (en.s4) begin
			m_s4 <= g * hvn_pkg::MIX_MUL_B;
		end
		if (en.s5) begin
			r_s5 <= $signed({1'b0, lo_byte} - hvn_pkg::BYTE_BIAS);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/hashed_value_noise_height_core.sv
// Top level: APB seed register and nine-stage bilinear value-noise pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one (pos_x, pos_y) Q32.32 position per cycle while in_ready is high and
// returns one Q6.32 height per input transfer, with every stage able to hold
// independently so a stalled result never loses or repeats an item. The stage
// count is set by the dependent chain of multiplies: the corner pre-multiply,
// the two avalanche multiplies of the hash, and the x and y interpolation
// products, each in a stage of its own. The seed sits at byte address 0 of the
// APB port and must be written only while the pipeline is empty.
module hashed_value_noise_height_core #(
	parameter int unsigned CELL_SHIFT = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output      logic [63:0]        prdata,
	output      logic               pready,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic signed [63:0] pos_x,
	input  wire logic signed [63:0] pos_y,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [37:0] height_z
);

	localparam int unsigned N = hvn_pkg::STAGES;

	logic [63:0]  seed_q;
	logic [31:0]  fold;
	logic [N:1]   vld_q;
	logic [N:1]   en;
	hvn_pkg::hash_en_t hen;

	logic [31:0] gx0_s1, gy0_s1;
	logic [15:0] tx_s1, ty_s1;
	logic [31:0] px0_s2, px1_s2, py0_s2, py1_s2;
	logic [15:0] tx_s2, tx_s3, tx_s4, tx_s5;
	logic [15:0] ty_s2, ty_s3, ty_s4, ty_s5, ty_s6, ty_s7;
	logic signed [8:0]  r00_s5, r10_s5, r01_s5, r11_s5;
	logic signed [8:0]  r00_s6, r01_s6;
	logic signed [26:0] p0_s6, p1_s6;
	logic signed [21:0] hx0_s7, hx1_s7, hx0_s8;
	logic signed [39:0] py_s8;
	logic signed [21:0] hxy_s9;

	logic signed [63:0] cell_x, cell_y;
	logic signed [9:0]  dx0, dx1;
	logic signed [22:0] dy;

	// configuration
	assign pready = 1'b1;
	assign fold   = seed_q[31:0] ^ seed_q[63:32];
	assign prdata = (paddr[3] == hvn_pkg::ADDR_SEED) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (psel && penable && pwrite && paddr[3] == hvn_pkg::ADDR_SEED) begin
			seed_q <= pwdata;
		end
	end

	// per-stage hold
	always_comb begin
		en[N] = !vld_q[N] || out_ready;
		for (int k = N - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[N];
	assign hen.s3    = en[3];
	assign hen.s4    = en[4];
	assign hen.s5    = en[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// datapath
	assign cell_x = pos_x >>> (32 + CELL_SHIFT);
	assign cell_y = pos_y >>> (32 + CELL_SHIFT);
	assign dx0    = 10'(r10_s5) - 10'(r00_s5);
	assign dx1    = 10'(r11_s5) - 10'(r01_s5);
	assign dy     = 23'(hx1_s7) - 23'(hx0_s7);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			gx0_s1 <= cell_x[31:0];
			gy0_s1 <= cell_y[31:0];
			tx_s1  <= pos_x[CELL_SHIFT + 31 : CELL_SHIFT + 16];
			ty_s1  <= pos_y[CELL_SHIFT + 31 : CELL_SHIFT + 16];
		end
		if (en[2]) begin
			px0_s2 <= gx0_s1 * hvn_pkg::HASH_MUL_X;
			px1_s2 <= (gx0_s1 + 32'd1) * hvn_pkg::HASH_MUL_X;
			py0_s2 <= gy0_s1 * hvn_pkg::HASH_MUL_Y;
			py1_s2 <= (gy0_s1 + 32'd1) * hvn_pkg::HASH_MUL_Y;
			tx_s2  <= tx_s1;
			ty_s2  <= ty_s1;
		end
		if (en[3]) begin
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
		end
		if (en[4]) begin
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
		end
		if (en[5]) begin
			tx_s5 <= tx_s4;
			ty_s5 <= ty_s4;
		end
		if (en[6]) begin
			p0_s6  <= 27'(dx0) * $signed({11'd0, tx_s5});
			p1_s6  <= 27'(dx1) * $signed({11'd0, tx_s5});
			r00_s6 <= r00_s5;
			r01_s6 <= r01_s5;
			ty_s6  <= ty_s5;
		end
		if (en[7]) begin
			hx0_s7 <= (22'(r00_s6) <<< 14) + 22'(p0_s6 >>> 2);
			hx1_s7 <= (22'(r01_s6) <<< 14) + 22'(p1_s6 >>> 2);
			ty_s7  <= ty_s6;
		end
		if (en[8]) begin
			py_s8  <= 40'(dy) * $signed({24'd0, ty_s7});
			hx0_s8 <= hx0_s7;
		end
		if (en[9]) begin
			hxy_s9 <= hx0_s8 + 22'(py_s8 >>> 16);
		end
	end

	assign height_z = $signed({hxy_s9, 16'd0});

	hvn_corner u_c00 (.clk(clk), .en(hen), .fold(fold), .px(px0_s2), .py(py0_s2), .r_s5(r00_s5));
	hvn_corner u_c10 (.clk(clk), .en(hen), .fold(fold), .px(px1_s2), .py(py0_s2), .r_s5(r10_s5));
	hvn_corner u_c01 (.clk(clk), .en(hen), .fold(fold), .px(px0_s2), .py(py1_s2), .r_s5(r01_s5));
	hvn_corner u_c11 (.clk(clk), .en(hen), .fold(fold), .px(px1_s2), .py(py1_s2), .r_s5(r11_s5));

	// checks
	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[N] |-> in_ready)
		else $error("input held off with an empty output stage");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !out_ready) |-> !in_ready)
		else $error("transfer accepted into a full stalled pipeline");

	a_stage1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[1] && !en[2]) |=> vld_q[1])
		else $error("held item dropped from the first stage");

endmodule
`default_nettype wire

### tb/hashed_value_noise_height_core_checker.sv
// Scoreboard for the value-noise height core: seed tracking, height prediction and comparison.
`timescale 1ns / 1ps
module hashed_value_noise_height_core_checker #(
	parameter int unsigned CELL_SHIFT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic [63:0] prdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] pos_x,
	input  logic [63:0] pos_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [37:0] height_z,
	output int          errors,
	output int          pending
);

	localparam logic [31:0] CORNER_MUL_X = 32'h85ebca6b;
	localparam logic [31:0] CORNER_MUL_Y = 32'hc2b2ae35;
	localparam logic [31:0] AVALANCHE_A  = 32'h7feb352d;
	localparam logic [31:0] AVALANCHE_B  = 32'h846ca68b;
	localparam logic [3:0]  SEED_ADDR    = {hvn_pkg::ADDR_SEED, 3'b000};

	logic [63:0] seed = '0;
	logic [37:0] heights_due[$];
	int          fails = 0;

	function automatic logic [31:0] cell_hash(input logic [63:0] s, input logic [31:0] gx,
			input logic [31:0] gy);
		logic [31:0] h;
		h = s[63:32] ^ s[31:0];
		h = h ^ (gx * CORNER_MUL_X);
		h = h ^ (gy * CORNER_MUL_Y);
		h = h ^ (h >> 16);
		h = h * AVALANCHE_A;
		h = h ^ (h >> 15);
		h = h * AVALANCHE_B;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic longint corner_lift(input logic [63:0] s, input logic [31:0] gx,
			input logic [31:0] gy);
		logic [31:0] h;
		h = cell_hash(s, gx, gy);
		return (longint'(h[7:0]) - 128) * 16384;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint t);
		return a + (((b - a) * t) >>> 16);
	endfunction

	function automatic logic [37:0] terrain_height(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] s);
		logic signed [31:0] wx, wy, cx, cy;
		logic [31:0]        gx1, gy1;
		longint             tx, ty, h00, h10, h01, h11, hx0, hx1, hxy;
		logic [63:0]        scaled;
		wx = x[63:32];
		wy = y[63:32];
		cx = wx >>> CELL_SHIFT;
		cy = wy >>> CELL_SHIFT;
		gx1 = cx + 32'd1;
		gy1 = cy + 32'd1;
		tx = longint'(x[CELL_SHIFT+31 -: 16]);
		ty = longint'(y[CELL_SHIFT+31 -: 16]);
		h00 = corner_lift(s, cx, cy);
		h10 = corner_lift(s, gx1, cy);
		h01 = corner_lift(s, cx, gy1);
		h11 = corner_lift(s, gx1, gy1);
		hx0 = blend(h00, h10, tx);
		hx1 = blend(h01, h11, tx);
		hxy = blend(hx0, hx1, ty);
		scaled = hxy <<< 16;
		return scaled[37:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [37:0] due;
		if (!arst_n) begin
			seed = '0;
			heights_due.delete();
			errors <= fails;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				heights_due.push_back(terrain_height(pos_x, pos_y, seed));
			if (out_valid && out_ready) begin
				if (heights_due.size() == 0) begin
					$error("height_z: expected none, got %0d", $signed(height_z));
					fails++;
				end else begin
					due = heights_due.pop_front();
					if (height_z !== due) begin
						$error("height_z: expected %0d, got %0d", $signed(due),
							$signed(height_z));
						fails++;
					end
				end
			end
			if (psel && penable && pready && paddr == SEED_ADDR) begin
				if (pwrite)
					seed = pwdata;
				else if (prdata !== seed) begin
					$error("prdata: expected %h, got %h", seed, prdata);
					fails++;
				end
			end
			errors <= fails;
			pending <= heights_due.size();
		end
	end

endmodule

### tb/hashed_value_noise_height_core_test.sv
// Testbench top for the value-noise height core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hashed_value_noise_height_core_test;

	localparam int unsigned CELL_SHIFT  = 5;
	localparam int          CYCLE_LIMIT = 300000;
	localparam logic [3:0]  SEED_ADDR   = {hvn_pkg::ADDR_SEED, 3'b000};
	localparam logic [3:0]  SPARE_ADDR  = {~hvn_pkg::ADDR_SEED, 3'b000};
	localparam logic [63:0] POS_MAX     = 64'h7fffffff_ffffffff;
	localparam logic [63:0] POS_MIN     = 64'h80000000_00000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [63:0] pos_x = '0;
	logic signed [63:0] pos_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [37:0] height_z;
	int                 errors;
	int                 pending;
	int                 cycle_count = 0;
	bit                 send_steady = 1'b0;

	hashed_value_noise_height_core #(
		.CELL_SHIFT(CELL_SHIFT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.height_z(height_z)
	);

	hashed_value_noise_height_core_checker #(
		.CELL_SHIFT(CELL_SHIFT)
	) height_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.height_z(height_z),
		.errors(errors),
		.pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_pos(input logic [63:0] x, input logic [63:0] y);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic apb_access(input logic write, input logic [3:0] addr,
			input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (hvn_pkg::STAGES + 4) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_coord();
		logic [63:0] v;
		int          w;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				w = $urandom_range(0, 4095);
				w = w - 2048;
				v[63:32] = w;
			end
			2: begin
				if ($urandom_range(0, 1))
					v[CELL_SHIFT+31:0] = '0;
				else
					v[CELL_SHIFT+31:0] = '1;
			end
			default: begin
				if ($urandom_range(0, 1))
					v = POS_MAX - $urandom_range(0, 255);
				else
					v = POS_MIN + $urandom_range(0, 255);
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [63:0] seed_value;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, cell boundaries, negative fractions and mid-cell points on the reset seed
		send_pos(64'h0, 64'h0);
		send_pos(POS_MAX, POS_MIN);
		send_pos(POS_MIN, POS_MAX);
		send_pos(POS_MIN, POS_MIN);
		send_pos(POS_MAX, POS_MAX);
		send_pos('1, '1);
		send_pos(64'hffffffff_80000000, 64'h00000000_80000000);
		send_pos({32'd32, 32'd0}, {32'd31, 32'hffffffff});
		send_pos({32'hffffffe0, 32'h0}, 64'hffffffe0_00000001);
		send_pos({32'h7fffffe0, 32'h0}, {32'h80000000, 32'hffffffff});
		send_pos({32'd16, 32'd0}, {32'hfffffff0, 32'd0});
		send_pos(64'h00000123_456789ab, 64'hfffffedc_ba987654);
		send_pos(64'h0000001f_ffff0000, 64'hffffffff_ffff0000);
		apb_access(1'b0, SEED_ADDR, '0);
		repeat (250) send_pos(pick_coord(), pick_coord());
		drain();

		for (int phase = 1; phase <= 5; phase++) begin
			case (phase)
				1: seed_value = '1;
				2: seed_value = 64'hdeadbeef_deadbeef;
				3: seed_value = 64'h01234567_89abcdef;
				default: seed_value = {$urandom, $urandom};
			endcase
			apb_access(1'b1, SEED_ADDR, seed_value);
			apb_access(1'b0, SEED_ADDR, '0);
			apb_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
			apb_access(1'b0, SEED_ADDR, '0);
			send_pos(POS_MIN, POS_MAX);
			send_pos('1, 64'h0);
			repeat (270) send_pos(pick_coord(), pick_coord());
			drain();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int stall;
		bit steady;
		steady = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

endmodule
